// ===== rtl/msfd_pkg.sv =====
// shared constants for the multi-server fifo dispatch block
package msfd_pkg;

  localparam int TIME_FIELDS = 4;   // service-time fields per input item
  localparam int ARR_W       = 4;
  localparam int DUR_W       = 4;
  localparam int ID_W        = 5;
  localparam int TICK_W      = 16;
  localparam int QLEN_W      = 5;
  localparam int SIDX_W      = 2;
  localparam int SC_W        = 3;
  localparam int MQL_W       = 5;
  localparam int WIN_W       = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [ID_W-1:0] ID_LAST = 5'd25;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SERVER_COUNT   = 2'd0;
  localparam logic [1:0] REG_MAX_QUEUE_LEN  = 2'd1;
  localparam logic [1:0] REG_ARRIVAL_WINDOW = 2'd2;

  localparam logic [SC_W-1:0]  SC_RESET  = 3'd4;
  localparam logic [MQL_W-1:0] MQL_RESET = 5'd16;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd10;

endpackage

// ===== rtl/multi_server_fifo_dispatch.sv =====
// tick-driven waiting line feeding several servers, line held in a sync ram
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | arrivals, service_time_0..3
//  out_    | output    | out_valid/out_ready| server_index, server_busy, customer_id,
//          |           |                    | queue_length, all_idle, last
//  apb     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// one item (tick) at a time: accept, free the servers whose service ends,
// enqueue the arrivals (only while the tick is inside the window, leaving the
// phase once the line is full), check each server in use and give a free one
// the line head read from the ram, then emit one result per server; out_ready
// stalls can hold each result. the next item is taken while the last result
// still waits in the output reg. rst_n is synchronous; no clearing pass, the
// line ram is only read where written.
module multi_server_fifo_dispatch #(
  parameter int MAX_SERVERS = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [msfd_pkg::ARR_W-1:0]     in_arrivals,
  input  logic [msfd_pkg::DUR_W-1:0]     in_service_time_0,
  input  logic [msfd_pkg::DUR_W-1:0]     in_service_time_1,
  input  logic [msfd_pkg::DUR_W-1:0]     in_service_time_2,
  input  logic [msfd_pkg::DUR_W-1:0]     in_service_time_3,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [msfd_pkg::SIDX_W-1:0]    out_server_index,
  output logic                           out_server_busy,
  output logic [msfd_pkg::ID_W-1:0]      out_customer_id,
  output logic [msfd_pkg::QLEN_W-1:0]    out_queue_length,
  output logic                           out_all_idle,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msfd_pkg::ADDR_W-1:0]    paddr,
  input  logic [msfd_pkg::DATA_W-1:0]    pwdata,
  output logic [msfd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int NSRV = (MAX_SERVERS < msfd_pkg::TIME_FIELDS) ? MAX_SERVERS
                                                              : msfd_pkg::TIME_FIELDS;
  localparam int SW   = (NSRV > 1) ? $clog2(NSRV) : 1;
  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LW   = (CW > msfd_pkg::MQL_W) ? CW : msfd_pkg::MQL_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FREE, ST_ENQ, ST_CHK, ST_ASG, ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [msfd_pkg::SC_W-1:0]  server_count_r;
  logic [msfd_pkg::MQL_W-1:0] max_queue_len_r;
  logic [msfd_pkg::WIN_W-1:0] arrival_window_r;

  // per-item and server state
  logic [msfd_pkg::TICK_W-1:0] tick_r;
  logic [msfd_pkg::ARR_W-1:0]  arr_left_r;
  logic [msfd_pkg::DUR_W-1:0]  svc_r [msfd_pkg::TIME_FIELDS];
  logic [SW-1:0]               srv_r;
  logic                        busy_r [NSRV];
  logic [msfd_pkg::TICK_W-1:0] end_r  [NSRV];
  logic [msfd_pkg::ID_W-1:0]   cust_r [NSRV];

  // waiting line
  logic [msfd_pkg::ID_W-1:0]   line_mem [QUEUE_DEPTH];
  logic [msfd_pkg::ID_W-1:0]   rdata_r;
  logic [AW-1:0]               head_r;
  logic [CW-1:0]               count_r;
  logic [msfd_pkg::ID_W-1:0]   next_id_r;

  logic [SW:0]                 n_use;
  logic [LW-1:0]               mql_ext;
  logic [LW-1:0]               lim;
  logic                        room;
  logic [AW:0]                 pos_sum;
  logic [AW-1:0]               wr_addr;
  logic                        wr_en;
  logic                        last_srv;
  logic                        idle;
  logic [msfd_pkg::DUR_W-1:0]  dur_raw;
  logic [msfd_pkg::DUR_W-1:0]  dur;
  logic                        out_free;

  // servers in use, clamped to 1..NSRV
  always_comb begin
    if (server_count_r == '0) begin
      n_use = (SW+1)'(1);
    end else if (32'(server_count_r) > NSRV) begin
      n_use = (SW+1)'(NSRV);
    end else begin
      n_use = (SW+1)'(server_count_r);
    end
  end

  assign mql_ext = LW'(max_queue_len_r);
  assign lim     = (mql_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : mql_ext;
  assign room    = LW'(count_r) < lim;

  // tail position, wraps at the line depth
  assign pos_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign wr_addr = (pos_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                   AW'(pos_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(pos_sum);
  assign wr_en   = (state_r == ST_ENQ) && room;

  assign last_srv = ((SW+1)'(srv_r) + (SW+1)'(1)) == n_use;
  assign dur_raw  = svc_r[msfd_pkg::SIDX_W'(srv_r)];
  assign dur      = (dur_raw == '0) ? msfd_pkg::DUR_W'(1) : dur_raw;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    idle = 1'b1;
    for (int i = 0; i < NSRV; i++) begin
      if (i < 32'(n_use) && busy_r[i]) begin
        idle = 1'b0;
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign pready   = 1'b1;

  // line ram: one write port, registered read of the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= next_id_r;
    end
    rdata_r <= line_mem[head_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_count_r   <= msfd_pkg::SC_RESET;
      max_queue_len_r  <= msfd_pkg::MQL_RESET;
      arrival_window_r <= msfd_pkg::WIN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        msfd_pkg::REG_SERVER_COUNT:   server_count_r   <= pwdata[msfd_pkg::SC_W-1:0];
        msfd_pkg::REG_MAX_QUEUE_LEN:  max_queue_len_r  <= pwdata[msfd_pkg::MQL_W-1:0];
        msfd_pkg::REG_ARRIVAL_WINDOW: arrival_window_r <= pwdata[msfd_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      msfd_pkg::REG_SERVER_COUNT:   prdata = msfd_pkg::DATA_W'(server_count_r);
      msfd_pkg::REG_MAX_QUEUE_LEN:  prdata = msfd_pkg::DATA_W'(max_queue_len_r);
      msfd_pkg::REG_ARRIVAL_WINDOW: prdata = msfd_pkg::DATA_W'(arrival_window_r);
      default:                      prdata = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tick_r     <= '0;
      arr_left_r <= '0;
      srv_r      <= '0;
      head_r     <= '0;
      count_r    <= '0;
      next_id_r  <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NSRV; i++) begin
        busy_r[i] <= 1'b0;
        end_r[i]  <= '0;
        cust_r[i] <= '0;
      end
    end else begin
      // the emit state loads the next result itself
      if (out_valid && out_ready && state_r != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            arr_left_r <= (tick_r < arrival_window_r) ? in_arrivals : '0;
            svc_r[0]   <= in_service_time_0;
            svc_r[1]   <= in_service_time_1;
            svc_r[2]   <= in_service_time_2;
            svc_r[3]   <= in_service_time_3;
            state_r    <= ST_FREE;
          end
        end
        ST_FREE: begin
          for (int i = 0; i < NSRV; i++) begin
            if (i < 32'(n_use) && busy_r[i] && end_r[i] == tick_r) begin
              busy_r[i] <= 1'b0;
            end
          end
          srv_r   <= '0;
          state_r <= (arr_left_r != '0) ? ST_ENQ : ST_CHK;
        end
        ST_ENQ: begin
          if (room) begin
            next_id_r <= (next_id_r >= msfd_pkg::ID_LAST) ? '0 : next_id_r + 1'b1;
            count_r   <= count_r + 1'b1;
          end
          arr_left_r <= arr_left_r - 1'b1;
          // a full line stays full for the rest of the enqueue phase
          if (arr_left_r == msfd_pkg::ARR_W'(1) || !room) begin
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          // head read is in flight this cycle, assignment uses it next cycle
          if (!busy_r[srv_r] && count_r != '0) begin
            state_r <= ST_ASG;
          end else if (last_srv) begin
            srv_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            srv_r <= srv_r + 1'b1;
          end
        end
        ST_ASG: begin
          cust_r[srv_r] <= rdata_r;
          end_r[srv_r]  <= tick_r + msfd_pkg::TICK_W'(dur);
          busy_r[srv_r] <= 1'b1;
          head_r        <= (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + 1'b1;
          count_r       <= count_r - 1'b1;
          if (last_srv) begin
            srv_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            srv_r   <= srv_r + 1'b1;
            state_r <= ST_CHK;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_server_index <= msfd_pkg::SIDX_W'(srv_r);
            out_server_busy  <= busy_r[srv_r];
            out_customer_id  <= busy_r[srv_r] ? cust_r[srv_r] : '0;
            out_queue_length <= msfd_pkg::QLEN_W'(count_r);
            out_all_idle     <= idle;
            out_last         <= last_srv;
            if (last_srv) begin
              tick_r  <= tick_r + 1'b1;
              state_r <= ST_IDLE;
            end else begin
              srv_r <= srv_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/msfd_checker.sv =====
// port-level checks for the multi-server fifo dispatch block, with bind
module msfd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [msfd_pkg::SIDX_W-1:0] out_server_index,
  input logic                        out_server_busy,
  input logic [msfd_pkg::ID_W-1:0]   out_customer_id,
  input logic [msfd_pkg::QLEN_W-1:0] out_queue_length,
  input logic                        out_all_idle,
  input logic                        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_server_index) &&
    $stable(out_server_busy) && $stable(out_customer_id) &&
    $stable(out_queue_length) && $stable(out_all_idle) && $stable(out_last))
    else $error("result changed while stalled");

  // one tick at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous tick in progress");

  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_server_busy |-> out_customer_id == '0)
    else $error("free server reports a customer");

  a_all_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_idle |-> !out_server_busy)
    else $error("busy server in an all-idle tick");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_customer_id <= msfd_pkg::ID_LAST)
    else $error("customer id out of range");

endmodule

bind multi_server_fifo_dispatch msfd_checker u_msfd_checker (.*);

// ===== verif/tb_top.sv =====
// testbench for multi_server_fifo_dispatch: per-tick prediction of server reports
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SRV        = 4;
  localparam int LINE_DEPTH     = 16;
  localparam int SRV_USED       = (MAX_SRV < msfd_pkg::TIME_FIELDS) ? MAX_SRV
                                                                    : msfd_pkg::TIME_FIELDS;
  localparam int ID_WRAP        = 25;
  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [msfd_pkg::ARR_W-1:0]                           arrivals;
    logic [msfd_pkg::TIME_FIELDS-1:0][msfd_pkg::DUR_W-1:0] svc;
  } tick_in_t;

  typedef struct packed {
    logic [msfd_pkg::SIDX_W-1:0] server_index;
    logic                        server_busy;
    logic [msfd_pkg::ID_W-1:0]   customer_id;
    logic [msfd_pkg::QLEN_W-1:0] queue_length;
    logic                        all_idle;
    logic                        last;
  } server_rpt_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [msfd_pkg::ARR_W-1:0]  in_arrivals;
  logic [msfd_pkg::DUR_W-1:0]  in_service_time_0;
  logic [msfd_pkg::DUR_W-1:0]  in_service_time_1;
  logic [msfd_pkg::DUR_W-1:0]  in_service_time_2;
  logic [msfd_pkg::DUR_W-1:0]  in_service_time_3;
  logic                        out_valid;
  logic                        out_ready;
  logic [msfd_pkg::SIDX_W-1:0] out_server_index;
  logic                        out_server_busy;
  logic [msfd_pkg::ID_W-1:0]   out_customer_id;
  logic [msfd_pkg::QLEN_W-1:0] out_queue_length;
  logic                        out_all_idle;
  logic                        out_last;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [msfd_pkg::ADDR_W-1:0] paddr;
  logic [msfd_pkg::DATA_W-1:0] pwdata;
  logic [msfd_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  multi_server_fifo_dispatch #(
    .MAX_SERVERS(MAX_SRV),
    .QUEUE_DEPTH(LINE_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_arrivals       (in_arrivals),
    .in_service_time_0 (in_service_time_0),
    .in_service_time_1 (in_service_time_1),
    .in_service_time_2 (in_service_time_2),
    .in_service_time_3 (in_service_time_3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_server_index  (out_server_index),
    .out_server_busy   (out_server_busy),
    .out_customer_id   (out_customer_id),
    .out_queue_length  (out_queue_length),
    .out_all_idle      (out_all_idle),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // predicted block state
  logic [msfd_pkg::SC_W-1:0]   cfg_servers;
  logic [msfd_pkg::MQL_W-1:0]  cfg_line_limit;
  logic [msfd_pkg::WIN_W-1:0]  cfg_window;
  logic [msfd_pkg::TICK_W-1:0] sim_tick;
  logic                        srv_busy [MAX_SRV];
  logic [msfd_pkg::TICK_W:0]   srv_end  [MAX_SRV];
  logic [msfd_pkg::ID_W-1:0]   srv_cust [MAX_SRV];
  logic [msfd_pkg::ID_W-1:0]   line_store [LINE_DEPTH];
  logic [3:0]                  line_head;
  logic [msfd_pkg::QLEN_W-1:0] line_len;
  logic [msfd_pkg::ID_W-1:0]   next_cust;

  server_rpt_t pending_reports [$];

  bit no_idle;
  int hold_left;
  int mismatches;
  int ticks_sent;
  int reports_seen;
  int idle_reports;
  int dropped;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic string rpt_str(input server_rpt_t r);
    return $sformatf("srv=%0d busy=%0d cust=%0d qlen=%0d idle=%0d last=%0d",
                     r.server_index, r.server_busy, r.customer_id, r.queue_length,
                     r.all_idle, r.last);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, what);
  endfunction

  function automatic tick_in_t make_tick(input int arr, input int s0, input int s1,
                                         input int s2, input int s3);
    tick_in_t t;
    t.arrivals = msfd_pkg::ARR_W'(arr);
    t.svc[0]   = msfd_pkg::DUR_W'(s0);
    t.svc[1]   = msfd_pkg::DUR_W'(s1);
    t.svc[2]   = msfd_pkg::DUR_W'(s2);
    t.svc[3]   = msfd_pkg::DUR_W'(s3);
    return t;
  endfunction

  // mostly light traffic so the line drains, with the odd burst up to fifteen
  function automatic tick_in_t random_tick();
    tick_in_t t;
    if ($urandom_range(0, 4) == 0) t.arrivals = msfd_pkg::ARR_W'($urandom_range(0, 15));
    else t.arrivals = msfd_pkg::ARR_W'($urandom_range(0, 3));
    for (int k = 0; k < msfd_pkg::TIME_FIELDS; k++)
      t.svc[k] = msfd_pkg::DUR_W'($urandom_range(0, 15));
    return t;
  endfunction

  function automatic void reset_line_state();
    cfg_servers    = msfd_pkg::SC_RESET;
    cfg_line_limit = msfd_pkg::MQL_RESET;
    cfg_window     = msfd_pkg::WIN_RESET;
    sim_tick       = '0;
    line_head      = '0;
    line_len       = '0;
    next_cust      = '0;
    for (int i = 0; i < MAX_SRV; i++) begin
      srv_busy[i] = 1'b0;
      srv_end[i]  = '0;
      srv_cust[i] = '0;
    end
  endfunction

  // one tick: free finished servers, enqueue arrivals, dispatch, then one report per server
  function automatic void advance_tick(input tick_in_t it);
    int n;
    int lim;
    int slot;
    logic [msfd_pkg::DUR_W-1:0] dur;
    logic [msfd_pkg::TICK_W-1:0] now;
    bit none_busy;
    server_rpt_t r;
    if (cfg_servers == 0) n = 1;
    else if (int'(cfg_servers) > SRV_USED) n = SRV_USED;
    else n = int'(cfg_servers);
    now = sim_tick;
    for (int i = 0; i < n; i++)
      if (srv_busy[i] && srv_end[i][msfd_pkg::TICK_W-1:0] == now) srv_busy[i] = 1'b0;
    if (now < cfg_window) begin
      lim = (int'(cfg_line_limit) > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_line_limit);
      for (int k = 0; k < int'(it.arrivals); k++) begin
        if (int'(line_len) < lim) begin
          slot = (int'(line_head) + int'(line_len)) % LINE_DEPTH;
          line_store[slot] = next_cust;
          next_cust = (int'(next_cust) >= ID_WRAP) ? '0 : next_cust + 1'b1;
          line_len++;
        end else begin
          dropped++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!srv_busy[i] && line_len != 0) begin
        dur = (it.svc[i] == 0) ? msfd_pkg::DUR_W'(1) : it.svc[i];
        srv_cust[i] = line_store[line_head];
        line_head++;
        line_len--;
        srv_end[i]  = {1'b0, now} + (msfd_pkg::TICK_W+1)'(dur);
        srv_busy[i] = 1'b1;
      end
    end
    none_busy = 1'b1;
    for (int i = 0; i < n; i++) if (srv_busy[i]) none_busy = 1'b0;
    for (int i = 0; i < n; i++) begin
      r.server_index = msfd_pkg::SIDX_W'(i);
      r.server_busy  = srv_busy[i];
      r.customer_id  = srv_busy[i] ? srv_cust[i] : '0;
      r.queue_length = line_len;
      r.all_idle     = none_busy;
      r.last         = (i == n - 1);
      pending_reports.push_back(r);
    end
    sim_tick = now + 1'b1;
  endfunction

  // input side: optional gap, then offer the item until it is taken
  task automatic send_tick(input tick_in_t it);
    if (!no_idle && $urandom_range(99) < 7) begin
      repeat ($urandom_range(1, 30)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_arrivals       <= it.arrivals;
    in_service_time_0 <= it.svc[0];
    in_service_time_1 <= it.svc[1];
    in_service_time_2 <= it.svc[2];
    in_service_time_3 <= it.svc[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    advance_tick(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [1:0] idx,
                          input logic [msfd_pkg::DATA_W-1:0] wdata,
                          output logic [msfd_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [msfd_pkg::DATA_W-1:0] want);
    logic [msfd_pkg::DATA_W-1:0] got;
    apb_xfer(1'b0, idx, '0, got);
    if (got !== want)
      note_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h", idx, got, want));
  endtask

  // write while idle, update the predicted settings, then read back
  task automatic cfg_write(input logic [1:0] idx, input int value);
    logic [msfd_pkg::DATA_W-1:0] unused;
    logic [msfd_pkg::DATA_W-1:0] stored;
    apb_xfer(1'b1, idx, msfd_pkg::DATA_W'(value), unused);
    case (idx)
      msfd_pkg::REG_SERVER_COUNT: begin
        cfg_servers = msfd_pkg::SC_W'(value);
        stored = msfd_pkg::DATA_W'(cfg_servers);
      end
      msfd_pkg::REG_MAX_QUEUE_LEN: begin
        cfg_line_limit = msfd_pkg::MQL_W'(value);
        stored = msfd_pkg::DATA_W'(cfg_line_limit);
      end
      default: begin
        cfg_window = msfd_pkg::WIN_W'(value);
        stored = msfd_pkg::DATA_W'(cfg_window);
      end
    endcase
    check_reg(idx, stored);
  endtask

  task automatic test_reset_defaults();
    check_reg(msfd_pkg::REG_SERVER_COUNT, msfd_pkg::DATA_W'(msfd_pkg::SC_RESET));
    check_reg(msfd_pkg::REG_MAX_QUEUE_LEN, msfd_pkg::DATA_W'(msfd_pkg::MQL_RESET));
    check_reg(msfd_pkg::REG_ARRIVAL_WINDOW, msfd_pkg::DATA_W'(msfd_pkg::WIN_RESET));
    // full burst overflows the line on the second tick
    send_tick(make_tick(15, 0, 15, 1, 2));
    send_tick(make_tick(15, 1, 1, 1, 1));
    send_tick(make_tick(0, 15, 15, 15, 15));
    send_tick(make_tick(1, 2, 3, 4, 5));
    send_tick(make_tick(0, 0, 0, 0, 0));
    send_tick(make_tick(7, 8, 9, 10, 11));
  endtask

  task automatic test_config_extremes();
    wait_drained();
    // zero servers acts as one, zero line limit drops everything
    cfg_write(msfd_pkg::REG_SERVER_COUNT, 0);
    cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, 0);
    cfg_write(msfd_pkg::REG_ARRIVAL_WINDOW, 16'hFFFF);
    send_tick(make_tick(15, 3, 15, 15, 15));
    send_tick(make_tick(15, 0, 1, 1, 1));
    send_tick(make_tick(8, 15, 2, 2, 2));
    wait_drained();
    // oversized counts clamp to their limits
    cfg_write(msfd_pkg::REG_SERVER_COUNT, 7);
    cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, 31);
    send_tick(make_tick(15, 15, 0, 15, 0));
    send_tick(make_tick(15, 1, 1, 1, 1));
    send_tick(make_tick(0, 6, 6, 6, 6));
    send_tick(make_tick(0, 4, 3, 2, 1));
    wait_drained();
    cfg_write(msfd_pkg::REG_SERVER_COUNT, 1);
    cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, 1);
    send_tick(make_tick(15, 2, 9, 9, 9));
    send_tick(make_tick(15, 1, 9, 9, 9));
    send_tick(make_tick(3, 0, 9, 9, 9));
  endtask

  task automatic test_random_mixes();
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      cfg_write(msfd_pkg::REG_SERVER_COUNT, (ph == 0) ? 4 : $urandom_range(0, 7));
      cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, (ph == 1) ? 16 : $urandom_range(0, 31));
      // window closes partway, so later ticks of the phase take no arrivals and the line can drain
      cfg_write(msfd_pkg::REG_ARRIVAL_WINDOW, int'(sim_tick) + $urandom_range(5, 40));
      no_idle = (ph == 3);
      repeat (42) send_tick(random_tick());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    wait_drained();
    cfg_write(msfd_pkg::REG_SERVER_COUNT, 4);
    cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, 16);
    cfg_write(msfd_pkg::REG_ARRIVAL_WINDOW, int'(sim_tick) + 30);
    no_idle   = 1'b1;
    hold_left = STALL_CYCLES;
    repeat (24) send_tick(random_tick());
    no_idle = 1'b0;
  endtask

  task automatic test_long_service();
    wait_drained();
    cfg_write(msfd_pkg::REG_SERVER_COUNT, 4);
    cfg_write(msfd_pkg::REG_MAX_QUEUE_LEN, 16);
    cfg_write(msfd_pkg::REG_ARRIVAL_WINDOW, 16'hFFFF);
    // long services overlap many ticks while the line keeps growing
    repeat (6) send_tick(make_tick(3, 15, 14, 13, 12));
    repeat (14) send_tick(random_tick());
  endtask

  always @(posedge clk) begin : result_side
    server_rpt_t got;
    server_rpt_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_server_index, out_server_busy, out_customer_id, out_queue_length,
             out_all_idle, out_last};
      reports_seen++;
      if (got.all_idle === 1'b1) idle_reports++;
      if (pending_reports.size() == 0) begin
        note_mismatch({"report with nothing expected: ", rpt_str(got)});
      end else begin
        want = pending_reports.pop_front();
        if (got !== want)
          note_mismatch({"expected ", rpt_str(want), " got ", rpt_str(got)});
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d reports outstanding",
               quiet_cycles, pending_reports.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_arrivals       <= '0;
    in_service_time_0 <= '0;
    in_service_time_1 <= '0;
    in_service_time_2 <= '0;
    in_service_time_3 <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    no_idle      = 1'b0;
    hold_left    = 0;
    mismatches   = 0;
    ticks_sent   = 0;
    dropped      = 0;
    reset_line_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_mixes();
    test_output_stall();
    test_long_service();

    wait_drained();
    $display("run covered %0d ticks and %0d server reports, %0d with all servers idle",
             ticks_sent, reports_seen, idle_reports);
    $display("%0d arrivals turned away at a full line", dropped);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
